@@ rtl/ftc_pkg.sv @@
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared types and constants of the filtered threshold counter: field widths,
// configuration register indexes, reset values and the divide-by-three factor.
// ----------------------------------------------------------------------------
package ftc_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_OUT_W = 16;
    localparam int ID_W        = 16;
    localparam int NUM_CLASSES = 4;
    localparam int OUT_DATA_W  = NUM_CLASSES * COUNT_OUT_W + ID_W;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WARNING_HIGH = 3'd0,
        REG_WARNING_LOW  = 3'd1,
        REG_ALARM_HIGH   = 3'd2,
        REG_ALARM_LOW    = 3'd3,
        REG_FILTER_MODE  = 3'd4,
        REG_RECORD_ID    = 3'd5
    } cfg_reg_t;

    // filter choice
    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

    // register reset values
    localparam logic signed [SAMPLE_W-1:0] WARNING_HIGH_RST = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] WARNING_LOW_RST  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] ALARM_HIGH_RST   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] ALARM_LOW_RST    = 16'sh8000;

    // class slots, also the order of the counts in the result
    localparam int CLS_WARNING_HIGH = 0;
    localparam int CLS_WARNING_LOW  = 1;
    localparam int CLS_ALARM_HIGH   = 2;
    localparam int CLS_ALARM_LOW    = 3;

    // samples classified raw at the start of a record
    localparam logic [1:0] WINDOW_FILL = 2'd2;

    // window sum and divide by three as multiply by reciprocal
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int MAG_W      = SUM_W - 1;
    localparam int MEAN_SHIFT = 20;
    localparam int RECIP_W    = 19;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 19'd349526;
    localparam int PROD_W     = MAG_W + RECIP_W;

    // controls handed to the window filter
    typedef struct packed {
        logic mode;
        logic window_full;
    } ftc_filter_ctrl_t;

endpackage

@@ rtl/ftc_filter.sv @@
// ----------------------------------------------------------------------------
// ftc_filter
// Three-sample window filter: median or truncating mean of the two previous
// samples and the current one; passes the sample raw while the window fills.
// ----------------------------------------------------------------------------
module ftc_filter
    import ftc_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] older,
    input  logic signed [SAMPLE_W-1:0] newer,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  ftc_filter_ctrl_t           ctrl,
    output logic signed [SAMPLE_W-1:0] value
);

    logic signed [SAMPLE_W-1:0] lo_ab;
    logic signed [SAMPLE_W-1:0] hi_ab;
    logic signed [SAMPLE_W-1:0] hi_c;
    logic signed [SAMPLE_W-1:0] median;
    logic signed [SUM_W-1:0]    sum;
    logic                       sum_neg;
    logic        [MAG_W-1:0]    mag;
    logic        [PROD_W-1:0]   prod;
    logic        [SAMPLE_W-1:0] quot;
    logic signed [SAMPLE_W:0]   mean_wide;
    logic signed [SAMPLE_W-1:0] mean;

    // median as max(min(a,b), min(max(a,b),c))
    always_comb
    begin
        lo_ab  = (older < newer) ? older : newer;
        hi_ab  = (older > newer) ? older : newer;
        hi_c   = (hi_ab < sample) ? hi_ab : sample;
        median = (lo_ab > hi_c) ? lo_ab : hi_c;
    end

    // mean: divide the magnitude by three, then restore the sign
    always_comb
    begin
        sum       = SUM_W'(older) + SUM_W'(newer) + SUM_W'(sample);
        sum_neg   = sum[SUM_W-1];
        mag       = sum_neg ? MAG_W'(-sum) : MAG_W'(sum);
        prod      = PROD_W'(mag) * PROD_W'(MEAN_RECIP);
        quot      = prod[MEAN_SHIFT +: SAMPLE_W];
        mean_wide = sum_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        mean      = mean_wide[SAMPLE_W-1:0];
    end

    // raw sample until the window holds two earlier samples
    always_comb
    begin
        if (!ctrl.window_full)
            value = sample;
        else if (ctrl.mode == MODE_MEAN)
            value = mean;
        else
            value = median;
    end

endmodule

@@ rtl/filtered_threshold_counter_core.sv @@
// ----------------------------------------------------------------------------
// filtered_threshold_counter_core
// Classifies a stream of signed sensor samples against four thresholds after
// a three-sample median or mean filter and counts each class per record.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample per transaction; s_tlast marks the last sample of
//   a record. m_* carries one result per record: the four class counts and
//   the record id. cfg_* writes the threshold, filter mode and record id
//   registers; it is always ready and should only be used while idle.
// Timing:
//   a sample goes into an input register, then the filter, the compare chain
//   and the counter update run combinationally into the counters and the
//   result register. One sample per cycle is sustained unless a closing sample
//   waits; a result shows on m_tvalid once its closing sample is consumed.
// Stall:
//   while a result waits on m_tready, samples that do not close a record keep
//   flowing; a closing sample waits in the input register until the result
//   register frees up, and s_tready drops only then.
// Reset:
//   rst_n clears the counters, window and valid flags and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module filtered_threshold_counter_core
    import ftc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
    input  logic                   s_tlast,   // last_sample
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] count_warning_high, [31:16] count_warning_low,
    // [47:32] count_alarm_high, [63:48] count_alarm_low, [79:64] sensor_id
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic signed [SAMPLE_W-1:0] warning_high_reg;
    logic signed [SAMPLE_W-1:0] warning_low_reg;
    logic signed [SAMPLE_W-1:0] alarm_high_reg;
    logic signed [SAMPLE_W-1:0] alarm_low_reg;
    logic                       filter_mode_reg;
    logic        [ID_W-1:0]     record_id_reg;

    // input register
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    // record state
    logic signed [SAMPLE_W-1:0] older_reg;
    logic signed [SAMPLE_W-1:0] newer_reg;
    logic        [1:0]          taken_reg;
    logic        [1:0]          taken_next;
    logic [COUNT_BITS-1:0]      count_reg  [NUM_CLASSES];
    logic [COUNT_BITS-1:0]      count_next [NUM_CLASSES];

    // result register
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic [OUT_DATA_W-1:0]      out_data_next;

    logic                       out_free;
    logic                       consume;
    logic                       accept;
    ftc_filter_ctrl_t           filt_ctrl;
    logic signed [SAMPLE_W-1:0] filt_value;
    logic [NUM_CLASSES-1:0]     class_hit;

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign consume   = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || consume;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warning_high_reg <= WARNING_HIGH_RST;
            warning_low_reg  <= WARNING_LOW_RST;
            alarm_high_reg   <= ALARM_HIGH_RST;
            alarm_low_reg    <= ALARM_LOW_RST;
            filter_mode_reg  <= MODE_MEDIAN;
            record_id_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WARNING_HIGH: warning_high_reg <= $signed(cfg_data);
                REG_WARNING_LOW:  warning_low_reg  <= $signed(cfg_data);
                REG_ALARM_HIGH:   alarm_high_reg   <= $signed(cfg_data);
                REG_ALARM_LOW:    alarm_low_reg    <= $signed(cfg_data);
                REG_FILTER_MODE:  filter_mode_reg  <= cfg_data[0];
                REG_RECORD_ID:    record_id_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= $signed(s_tdata);
            in_last_reg   <= s_tlast;
        end
    end

    // window filter
    assign filt_ctrl.mode        = filter_mode_reg;
    assign filt_ctrl.window_full = (taken_reg >= WINDOW_FILL);

    ftc_filter u_filter
    (
        .older  (older_reg),
        .newer  (newer_reg),
        .sample (in_sample_reg),
        .ctrl   (filt_ctrl),
        .value  (filt_value)
    );

    // priority classification
    always_comb
    begin
        class_hit = '0;
        if (filt_value >= warning_high_reg)
            class_hit[CLS_WARNING_HIGH] = 1'b1;
        else if (filt_value <= warning_low_reg)
            class_hit[CLS_WARNING_LOW] = 1'b1;
        else if (filt_value > alarm_high_reg)
            class_hit[CLS_ALARM_HIGH] = 1'b1;
        else if (filt_value < alarm_low_reg)
            class_hit[CLS_ALARM_LOW] = 1'b1;
    end

    // saturating counters and window fill count
    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (class_hit[k] && (count_reg[k] != COUNT_MAX))
                count_next[k] = count_reg[k] + COUNT_BITS'(1);
            else
                count_next[k] = count_reg[k];
        end
        taken_next = filt_ctrl.window_full ? taken_reg : taken_reg + 2'd1;
    end

    // result word from the updated counts
    always_comb
    begin
        out_data_next = {record_id_reg,
                         COUNT_OUT_W'(count_next[CLS_ALARM_LOW]),
                         COUNT_OUT_W'(count_next[CLS_ALARM_HIGH]),
                         COUNT_OUT_W'(count_next[CLS_WARNING_LOW]),
                         COUNT_OUT_W'(count_next[CLS_WARNING_HIGH])};
    end

    // record state update, cleared after the closing sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            taken_reg <= '0;
            for (int k = 0; k < NUM_CLASSES; k++)
                count_reg[k] <= '0;
        end
        else if (consume)
        begin
            if (in_last_reg)
            begin
                older_reg <= '0;
                newer_reg <= '0;
                taken_reg <= '0;
                for (int k = 0; k < NUM_CLASSES; k++)
                    count_reg[k] <= '0;
            end
            else
            begin
                older_reg <= newer_reg;
                newer_reg <= in_sample_reg;
                taken_reg <= taken_next;
                for (int k = 0; k < NUM_CLASSES; k++)
                    count_reg[k] <= count_next[k];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (consume && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
            out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/ftc_checker.sv @@
// ----------------------------------------------------------------------------
// ftc_checker
// Port-level checks of the filtered threshold counter, bound to the top level.
// ----------------------------------------------------------------------------
module ftc_checker
    import ftc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  cfg_ready
);

    // a stalled result transaction holds its valid and data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result transaction changed");

    // with room in the result register the sample input never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
    else $error("sample input stalled while result side was free");

    // no result right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
    else $error("result valid straight out of reset");

    // configuration writes are never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("configuration port not ready");

endmodule

bind filtered_threshold_counter_core ftc_checker u_ftc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
